// ===== rtl/button_debounce_long_press_assert.svh =====
// Assertion macros for the button debounce / long-press block.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BDLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BDLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce / long-press block.
// No dependencies.
`default_nettype none

package bdlp_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int TIMER_WIDTH = 24;
	localparam int PIN_W       = 4;
	localparam int SEL_W       = 2;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CNT_W-1:0]       DEBOUNCE_RST  = CNT_W'(3);
	localparam logic [TIMER_WIDTH-1:0] THRESHOLD_RST = TIMER_WIDTH'(1000000);
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX_RST = TIMER_WIDTH'(16777215);
	localparam logic [PIN_W-1:0]       IDLE_RST      = PIN_W'(12);

	typedef enum logic {
		KIND_POLL  = 1'b0,
		KIND_CHECK = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_RELEASED = 2'd1,
		EV_PUSHED   = 2'd2,
		EV_HOLD     = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE  = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_TIMER_MAX = 2'd2,
		CFG_IDLE      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]       debounce_polls;
		logic [TIMER_WIDTH-1:0] hold_threshold;
		logic [TIMER_WIDTH-1:0] timer_max;
	} cfg_t;

	// per-lane command for one accepted item
	typedef struct packed {
		logic                   poll_en;
		logic                   chk_en;
		logic                   pin;
		logic                   idle;
		logic [TIMER_WIDTH-1:0] now;
	} lane_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bdlp_req_if.sv =====
// Input item channel: poll or check request.
// Depends on bdlp_pkg.
`default_nettype none

interface bdlp_req_if;
	import bdlp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [PIN_W-1:0]       pin_levels;
	logic [TIMER_WIDTH-1:0] timer_now;
	logic [SEL_W-1:0]       button_select;

	modport source (output valid, kind, pin_levels, timer_now, button_select, input ready);
	modport sink (input valid, kind, pin_levels, timer_now, button_select, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdlp_rsp_if.sv =====
// Result item channel: one event per check item.
// Depends on bdlp_pkg.
`default_nettype none

interface bdlp_rsp_if;
	import bdlp_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] event_res;

	modport source (output valid, event_res, input ready);
	modport sink (input valid, event_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdlp_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on bdlp_pkg.
`default_nettype none

interface bdlp_cfg_if;
	import bdlp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdlp_lane.sv =====
// One button lane: debounce counter, stable level, press stamp, hold detect, flags.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bdlp_pkg::lane_cmd_t cmd,
	input  wire bdlp_pkg::cfg_t    cfg,
	input  wire logic              rst_level,
	output bdlp_pkg::event_t       ev
);
	import bdlp_pkg::*;

	localparam int DW = TIMER_WIDTH + 2;

	// level stored relative to its reset value so reset clears it
	logic                   rel_q, rel_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   chg_q, chg_d;
	logic                   hold_q, hold_d;
	logic                   sv_q, sv_d;
	logic [TIMER_WIDTH-1:0] stamp_q;
	logic                   stamp_we;

	logic                   stable;
	logic [CNT_W-1:0]       cnt_inc;
	logic signed [DW-1:0]   d_raw, d_wrap, d_sel, thr_s;
	logic                   over;

	assign stable  = rel_q ^ rst_level;
	assign cnt_inc = (cnt_q != {CNT_W{1'b1}}) ? cnt_q + CNT_W'(1) : cnt_q;

	assign d_raw  = signed'({2'b00, stamp_q}) - signed'({2'b00, cmd.now});
	assign d_wrap = d_raw + signed'({2'b00, cfg.timer_max});
	assign d_sel  = d_raw[DW-1] ? d_wrap : d_raw;
	assign thr_s  = signed'({2'b00, cfg.hold_threshold});
	assign over   = d_sel > thr_s;

	always_comb begin
		if (chg_q) begin
			ev = (stable == cmd.idle) ? EV_RELEASED : EV_PUSHED;
		end else if (hold_q) begin
			ev = EV_HOLD;
		end else begin
			ev = EV_NONE;
		end
	end

	always_comb begin
		rel_d    = rel_q;
		cnt_d    = cnt_q;
		chg_d    = chg_q;
		hold_d   = hold_q;
		sv_d     = sv_q;
		stamp_we = 1'b0;
		if (cmd.poll_en) begin
			if (cmd.pin != stable) begin
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.debounce_polls) begin
					rel_d = cmd.pin ^ rst_level;
					chg_d = 1'b1;
					cnt_d = '0;
					if (cmd.pin != cmd.idle) begin
						stamp_we = 1'b1;
						sv_d     = 1'b1;
					end else begin
						sv_d = 1'b0;
					end
				end
			end else begin
				cnt_d = '0;
				if (sv_q && over) begin
					hold_d = 1'b1;
				end
			end
		end else if (cmd.chk_en) begin
			if (chg_q) begin
				chg_d = 1'b0;
			end else begin
				hold_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q  <= 1'b0;
			cnt_q  <= '0;
			chg_q  <= 1'b0;
			hold_q <= 1'b0;
			sv_q   <= 1'b0;
		end else begin
			rel_q  <= rel_d;
			cnt_q  <= cnt_d;
			chg_q  <= chg_d;
			hold_q <= hold_d;
			sv_q   <= sv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_q <= cmd.now;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bdlp_merge.sv =====
// Merge stage: picks the selected lane's event and holds it in the output register.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire bdlp_pkg::event_t [bdlp_pkg::NUM_BUTTONS-1:0] lane_ev,
	input  wire logic [bdlp_pkg::SEL_W-1:0]             sel,
	input  wire logic                                   load,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output bdlp_pkg::event_t                            out_event
);
	import bdlp_pkg::*;

	logic   valid_q;
	event_t ev_q;
	event_t pick;

	// a select past the last button answers no change
	always_comb begin
		pick = EV_NONE;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (32'(sel) == i) begin
				pick = lane_ev[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q <= pick;
		end
	end

	assign out_valid = valid_q;
	assign out_event = ev_q;

endmodule

`default_nettype wire

// ===== rtl/button_debounce_long_press.sv =====
// Top level of the four-button debouncer with long-press detection.
// Depends on bdlp_pkg, the channel interfaces, bdlp_lane and bdlp_merge.
//
// Usage:
//   req  - item channel. kind poll carries pin_levels and timer_now and updates
//          every button lane at once; kind check reads and clears the reported flag of
//          button_select and yields one result item on rsp.
//   rsp  - one event_res per check: no change, released, pushed or hold.
//   cfg  - register writes (debounce polls, hold threshold, timer max, idle
//          levels); always ready, take effect on the next item.
// Throughput is one item per cycle while req is ready. A check result appears
// on rsp the cycle after the item is accepted and sits in a single output
// register; req stays ready while that register is empty or being taken in
// the same cycle, so a stalled receiver holds off req only while a result
// waits. The lane update (one subtract, wrap add and threshold compare per
// button) sets the cycle. After reset each stable level equals its reset idle
// bit, all counters and flags are clear, no press is recorded and the registers
// hold their reset values.
`default_nettype none
`include "button_debounce_long_press_assert.svh"

module button_debounce_long_press (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdlp_req_if.sink   req,
	bdlp_rsp_if.source rsp,
	bdlp_cfg_if.sink   cfg
);
	import bdlp_pkg::*;

	cfg_t             cfg_q;
	logic [PIN_W-1:0] idle_q;
	logic             accept;
	logic             rsp_valid;
	event_t           rsp_event;
	lane_cmd_t        cmd [NUM_BUTTONS];
	event_t [NUM_BUTTONS-1:0] lane_ev;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_polls <= DEBOUNCE_RST;
			cfg_q.hold_threshold <= THRESHOLD_RST;
			cfg_q.timer_max      <= TIMER_MAX_RST;
			idle_q               <= IDLE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_DEBOUNCE:  cfg_q.debounce_polls <= cfg.data[CNT_W-1:0];
				CFG_THRESHOLD: cfg_q.hold_threshold <= cfg.data[TIMER_WIDTH-1:0];
				CFG_TIMER_MAX: cfg_q.timer_max      <= cfg.data[TIMER_WIDTH-1:0];
				CFG_IDLE:      idle_q               <= cfg.data[PIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = !rsp_valid || rsp.ready;
	assign accept    = req.valid && req.ready;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic pin_bit, idle_bit, rst_bit;

		// buttons past the pin field read a low level
		if (i < PIN_W) begin : g_bit
			assign pin_bit  = req.pin_levels[i];
			assign idle_bit = idle_q[i];
			assign rst_bit  = IDLE_RST[i];
		end else begin : g_zero
			assign pin_bit  = 1'b0;
			assign idle_bit = 1'b0;
			assign rst_bit  = 1'b0;
		end

		assign cmd[i].poll_en = accept && (kind_t'(req.kind) == KIND_POLL);
		assign cmd[i].chk_en  = accept && (kind_t'(req.kind) == KIND_CHECK)
			&& (32'(req.button_select) == i);
		assign cmd[i].pin     = pin_bit;
		assign cmd[i].idle    = idle_bit;
		assign cmd[i].now     = req.timer_now;

		bdlp_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[i]),
			.cfg       (cfg_q),
			.rst_level (rst_bit),
			.ev        (lane_ev[i])
		);
	end

	bdlp_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lane_ev   (lane_ev),
		.sel       (req.button_select),
		.load      (accept && (kind_t'(req.kind) == KIND_CHECK)),
		.out_ready (rsp.ready),
		.out_valid (rsp_valid),
		.out_event (rsp_event)
	);

	assign rsp.valid     = rsp_valid;
	assign rsp.event_res = rsp_event;

	`BDLP_ASSERT_NXT(a_check_gives_result, clk, arst_n, accept && req.kind, rsp.valid, "check item produced no result")
	`BDLP_ASSERT_NXT(a_poll_no_result, clk, arst_n, accept && !req.kind && !(rsp.valid && !rsp.ready), !rsp.valid, "poll item produced a result")
	`BDLP_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !req.ready, rsp.valid && !rsp.ready, "input stalled with output free")

endmodule

`default_nettype wire

// ===== sim/bdlp_event_checker.sv =====
// Checker for the button debounce / long-press block: watches the item, result and
// register channels, predicts the event of every check item and compares it.
// Depends on bdlp_pkg and the bdlp_req_if, bdlp_rsp_if and bdlp_cfg_if interfaces.
`default_nettype none

module bdlp_event_checker
	import bdlp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bdlp_req_if       req,
	bdlp_rsp_if       rsp,
	bdlp_cfg_if       cfg,
	output int        mismatches,
	output int        pending
);

	// register copies
	logic [CNT_W-1:0]       polls_needed;
	logic [TIMER_WIDTH-1:0] long_ticks;
	logic [TIMER_WIDTH-1:0] reload;
	logic [PIN_W-1:0]       idle_pins;

	// per-button state
	logic                   settled     [NUM_BUTTONS];
	logic [CNT_W-1:0]       disagree    [NUM_BUTTONS];
	logic                   moved       [NUM_BUTTONS];
	logic                   held        [NUM_BUTTONS];
	logic [TIMER_WIDTH-1:0] pressed_at  [NUM_BUTTONS];
	logic                   press_known [NUM_BUTTONS];

	event_t awaited_events[$];
	event_t oldest;

	task automatic take_poll(input logic [PIN_W-1:0] pins, input logic [TIMER_WIDTH-1:0] now);
		longint elapsed;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (pins[b] != settled[b]) begin
				if (disagree[b] != '1)
					disagree[b] = disagree[b] + 1'b1;
				if (disagree[b] >= polls_needed) begin
					settled[b]  = pins[b];
					moved[b]    = 1'b1;
					disagree[b] = '0;
					if (pins[b] != idle_pins[b]) begin
						pressed_at[b]  = now;
						press_known[b] = 1'b1;
					end else begin
						// hold flag survives a release until a check reports it
						press_known[b] = 1'b0;
					end
				end
			end else begin
				disagree[b] = '0;
				if (press_known[b]) begin
					elapsed = longint'(pressed_at[b]) - longint'(now);
					if (elapsed < 0)
						elapsed += longint'(reload);
					if (elapsed > longint'(long_ticks))
						held[b] = 1'b1;
				end
			end
		end
	endtask

	// change flag wins over hold; only the reported flag clears
	function automatic event_t read_button(input logic [SEL_W-1:0] sel);
		if (moved[sel]) begin
			moved[sel] = 1'b0;
			return (settled[sel] == idle_pins[sel]) ? EV_RELEASED : EV_PUSHED;
		end
		if (held[sel]) begin
			held[sel] = 1'b0;
			return EV_HOLD;
		end
		return EV_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polls_needed = DEBOUNCE_RST;
			long_ticks   = THRESHOLD_RST;
			reload       = TIMER_MAX_RST;
			idle_pins    = IDLE_RST;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				settled[b]     = IDLE_RST[b];
				disagree[b]    = '0;
				moved[b]       = 1'b0;
				held[b]        = 1'b0;
				pressed_at[b]  = '0;
				press_known[b] = 1'b0;
			end
			awaited_events.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// results leave from the output register after their check is accepted, so compare before queueing new ones
			if (rsp.valid && rsp.ready) begin
				if (awaited_events.size() == 0) begin
					$error("event_res: expected nothing, got %0d", rsp.event_res);
					mismatches++;
				end else begin
					oldest = awaited_events.pop_front();
					if (rsp.event_res !== oldest) begin
						$error("event_res: expected %0d (%s), got %0d",
							oldest, oldest.name(), rsp.event_res);
						mismatches++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_DEBOUNCE:  polls_needed = cfg.data[CNT_W-1:0];
					CFG_THRESHOLD: long_ticks   = cfg.data[TIMER_WIDTH-1:0];
					CFG_TIMER_MAX: reload       = cfg.data[TIMER_WIDTH-1:0];
					CFG_IDLE:      idle_pins    = cfg.data[PIN_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (kind_t'(req.kind) == KIND_POLL)
					take_poll(req.pin_levels, req.timer_now);
				else
					awaited_events.push_back(read_button(req.button_select));
			end
			pending = awaited_events.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/button_debounce_long_press_tb.sv =====
// Top of the button debounce / long-press testbench: clock, reset, poll and check
// stimulus, register phases, result-side stalls and the verdict.
// Depends on bdlp_pkg, the channel interfaces, the DUT and bdlp_event_checker.
`default_nettype none

module button_debounce_long_press_tb;
	import bdlp_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int SETTLE_CYCLES   = 4;

	logic clk = 1'b0;
	logic arst_n;

	bdlp_req_if req_ch ();
	bdlp_rsp_if rsp_ch ();
	bdlp_cfg_if cfg_ch ();

	int mismatches;
	int pending;
	int quiet_cycles = 0;

	bit calm          = 1'b0;
	bit hold_off_req  = 1'b0;
	bit hold_off_done = 1'b0;

	// stimulus-side view of the registers and the free-running timer
	int polls_needed_now = int'(DEBOUNCE_RST);
	int reload_now       = int'(TIMER_MAX_RST);
	int tick             = int'(TIMER_MAX_RST);
	int tick_step        = 1000;

	button_debounce_long_press dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	bdlp_event_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls plus one long hold-off on request
	initial begin
		int g;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				g = calm ? 0 : pick_gap();
				if (g > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance with valid high
	task automatic send_req(input kind_t k, input logic [PIN_W-1:0] pins,
		input logic [TIMER_WIDTH-1:0] now, input logic [SEL_W-1:0] sel);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= k;
		req_ch.pin_levels    <= pins;
		req_ch.timer_now     <= now;
		req_ch.button_select <= sel;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic poll(input logic [PIN_W-1:0] pins, input logic [TIMER_WIDTH-1:0] now);
		send_req(KIND_POLL, pins, now, SEL_W'($urandom));
	endtask

	task automatic check_button(input logic [SEL_W-1:0] sel);
		send_req(KIND_CHECK, PIN_W'($urandom), TIMER_WIDTH'($urandom), sel);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		if (idx == CFG_DEBOUNCE)
			polls_needed_now = int'(value[CNT_W-1:0]);
		if (idx == CFG_TIMER_MAX) begin
			reload_now = int'(value);
			tick       = int'(value);
		end
	endtask

	task automatic set_all(input int dbp, input int thr, input int tmax, input int idle);
		write_reg(CFG_DEBOUNCE, CFG_DATA_W'(dbp));
		write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(CFG_TIMER_MAX, CFG_DATA_W'(tmax));
		write_reg(CFG_IDLE, CFG_DATA_W'(idle));
		cfg_ch.valid <= 1'b0;
	endtask

	// lower valid, wait for every result, then let in-flight polls settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// down-counting timer, reloads from timer_max after zero
	task automatic advance_tick();
		int step;
		step = $urandom_range(1, tick_step);
		if (step > reload_now)
			step = reload_now;
		tick = (tick + reload_now + 1 - step) % (reload_now + 1);
	endtask

	// runs of polls held at one target level long enough to debounce, with checks mixed in,
	// and bounce and noise polls too while the debounce count is at most 8
	task automatic random_stream(input int count);
		logic [PIN_W-1:0] target;
		logic [PIN_W-1:0] pins;
		int run;
		int r;
		int flip;
		bit clean;
		run    = 0;
		target = '0;
		clean  = polls_needed_now > 8;
		for (int n = 0; n < count; n++) begin
			if (run == 0) begin
				target = PIN_W'($urandom_range(0, 15));
				run    = polls_needed_now + $urandom_range(1, 10);
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				check_button(SEL_W'($urandom_range(0, 3)));
			end else if (r < 17 && !clean) begin
				poll(PIN_W'($urandom), TIMER_WIDTH'($urandom));
			end else begin
				pins = target;
				if (r < 27 && !clean) begin
					flip       = $urandom_range(0, PIN_W - 1);
					pins[flip] = ~pins[flip];
				end
				advance_tick();
				poll(pins, TIMER_WIDTH'(tick));
				run--;
			end
		end
	endtask

	initial begin
		req_ch.valid         = 1'b0;
		req_ch.kind          = KIND_POLL;
		req_ch.pin_levels    = '0;
		req_ch.timer_now     = '0;
		req_ch.button_select = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = CFG_DEBOUNCE;
		cfg_ch.data          = '0;
		arst_n               = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, on reset register values
		for (int b = 0; b < NUM_BUTTONS; b++)
			check_button(SEL_W'(b));
		repeat (3) poll(4'b0011, 24'd1000);
		poll(4'b0011, 24'd15000000);          // wrapped elapsed time beyond threshold
		repeat (3) check_button(2'd0);        // pushed, then hold, then nothing
		repeat (2) poll(4'b1100, 24'hFFFFFF);
		poll(4'b0011, 24'hFFFFFF);            // bounce clears the count
		repeat (3) poll(4'b1100, 24'd0);      // release, hold flags remain
		check_button(2'd1);
		check_button(2'd1);
		check_button(2'd2);
		check_button(2'd3);
		poll(4'b1111, 24'hFFFFFF);
		poll(4'b0000, 24'd0);
		drain();

		// low extremes: one poll changes a level, any elapsed tick is a hold
		set_all(0, 0, 1, 0);
		tick_step = 1;
		random_stream(40);
		drain();

		// high extremes: long runs needed, hold never reachable
		set_all(255, 16777215, 16777215, 15);
		tick_step = 100000;
		random_stream(330);
		drain();

		// mid settings, sender never idles while the receiver holds off
		set_all(3, 800, 6000, 5);
		tick_step    = 300;
		calm         = 1'b1;
		hold_off_req = 1'b1;
		random_stream(35);
		drain();
		random_stream(35);
		drain();
		calm = 1'b0;

		// idle levels rewritten alone: stable levels stay where they are
		write_reg(CFG_IDLE, CFG_DATA_W'(4'b1010));
		cfg_ch.valid <= 1'b0;
		random_stream(40);
		drain();

		repeat (2) begin
			set_all($urandom_range(1, 5), $urandom_range(0, 2000),
				$urandom_range(1000, 70000), $urandom_range(0, 15));
			tick_step = 600;
			random_stream(25);
			drain();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
